FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the top-level RTL; they compile away under SYNTH.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: hdl/tcco_pkg.sv
// ---------------------------------------------------------------------------
// Cursor overlay package
// Shared widths, codes and the records passed between front, queue and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcco_pkg;

   localparam int MAX_CURSOR_DEF = 64;
   localparam int COORD_BITS_DEF = 12;
   localparam int QUEUE_DEPTH    = 4;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 6;    // bitmap row / column index
   localparam int MAP_W      = 64;   // one bitmap row
   localparam int PIXEL_W    = 32;
   localparam int COLOR_W    = 24;
   localparam int REG16_W    = 16;
   localparam int DIM_W      = 8;
   // screen coordinate (up to 16 bits) minus origin plus mask offset
   localparam int DIFF_W     = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [OP_W-1:0] OP_PIXEL     = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_SRC  = 2'd1;
   localparam logic [OP_W-1:0] OP_LOAD_MASK = 2'd2;

   typedef enum logic [1:0] {
      KIND_PIXEL,
      KIND_LOAD_SRC,
      KIND_LOAD_MASK
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURSOR_X,
      CSR_CURSOR_Y,
      CSR_MASK_ENABLE,
      CSR_MASK_OFFSET,
      CSR_SOURCE_SIZE,
      CSR_MASK_SIZE,
      CSR_FORE_COLOR,
      CSR_BACK_COLOR
   } csr_index_type;

   typedef struct packed {
      logic signed [REG16_W-1:0] cursor_x;
      logic signed [REG16_W-1:0] cursor_y;
      logic                      mask_enable;
      logic [REG16_W-1:0]        mask_offset;
      logic [REG16_W-1:0]        source_size;
      logic [REG16_W-1:0]        mask_size;
      logic [COLOR_W-1:0]        fore_color;
      logic [COLOR_W-1:0]        back_color;
   } cfg_type;

   // classified item, one queue entry
   typedef struct packed {
      kind_type           kind;
      logic [ROW_W-1:0]   src_row;    // also the write row of a load
      logic [ROW_W-1:0]   src_col;
      logic [ROW_W-1:0]   mask_row;
      logic [ROW_W-1:0]   mask_col;
      logic               src_in;
      logic               mask_in;
      logic               use_mask;
      logic [MAP_W-1:0]   data;       // row bits, or under pixel in the low bits
   } work_type;

   typedef struct packed {
      logic             we;
      logic             re;
      logic [ROW_W-1:0] waddr;
      logic [ROW_W-1:0] raddr;
      logic [MAP_W-1:0] wdata;
   } ram_req_type;

   typedef struct packed {
      logic b1_hold;
   } back_stat_type;

endpackage

FILE: hdl/tcco_req_if.sv
// ---------------------------------------------------------------------------
// Request channel
// Pixel and bitmap load items into the overlay.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcco_req_if #(parameter int COORD_BITS = tcco_pkg::COORD_BITS_DEF);
   import tcco_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_W-1:0]       op;
   logic [COORD_BITS-1:0] pix_x;
   logic [COORD_BITS-1:0] pix_y;
   logic [PIXEL_W-1:0]    under_pixel;
   logic [ROW_W-1:0]      row_index;
   logic [MAP_W-1:0]      row_bits;

   modport source (output valid, op, pix_x, pix_y, under_pixel, row_index, row_bits,
                   input ready);
   modport sink   (input valid, op, pix_x, pix_y, under_pixel, row_index, row_bits,
                   output ready);
endinterface

FILE: hdl/tcco_rsp_if.sv
// ---------------------------------------------------------------------------
// Response channel
// One result item per pixel item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcco_rsp_if;
   import tcco_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] out_pixel;
   logic               covered;

   modport source (output valid, out_pixel, covered, input ready);
   modport sink   (input valid, out_pixel, covered, output ready);
endinterface

FILE: hdl/tcco_csr_if.sv
// ---------------------------------------------------------------------------
// Register write channel
// Index and data of one configuration register write.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tcco_csr_if;
   import tcco_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/two_color_cursor_overlay_top.sv
// ---------------------------------------------------------------------------
// Two-color cursor overlay
// Masked 1-bit cursor drawn over a pixel stream, with bitmap row loads.
// ---------------------------------------------------------------------------
//  channel   dir  handshake          carries
//  req_bus   in   valid / ready      op, pix_x, pix_y, under_pixel, row_index, row_bits
//  rsp_bus   out  valid / ready      out_pixel, covered (pixel items only)
//  csr_bus   in   valid / ready = 1  index, data
//
//  One item per cycle sustained while rsp ready stays high; a pixel result
//  passes the front register, queue, lookup stage and output register. The
//  rate is set by the back end popping one queue entry per cycle and doing
//  one bitmap RAM access per RAM per item. Reset clears the registers and
//  empties the pipeline; bitmap rows hold no reset value and must be loaded
//  before use. With rsp ready low the output stage, lookup stage, a four-entry
//  queue and the front register fill before req ready drops.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module two_color_cursor_overlay_top #(
   parameter int MAX_CURSOR = tcco_pkg::MAX_CURSOR_DEF,
   parameter int COORD_BITS = tcco_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   tcco_req_if.sink   req_bus,
   tcco_rsp_if.source rsp_bus,
   tcco_csr_if.sink   csr_bus
);
   import tcco_pkg::*;

   localparam int ADDR_W = (MAX_CURSOR > 1) ? $clog2(MAX_CURSOR) : 1;

   cfg_type       cfg_ff;
   work_type      push_item, pop_item;
   logic          push_valid, push_ready, pop_valid, pop_ready;
   ram_req_type   src_req, mask_req;
   logic [MAP_W-1:0] src_rdata, mask_rdata;
   back_stat_type bk_stat;

   // register file
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_CURSOR_X:    cfg_ff.cursor_x    <= $signed(csr_bus.data[REG16_W-1:0]);
            CSR_CURSOR_Y:    cfg_ff.cursor_y    <= $signed(csr_bus.data[REG16_W-1:0]);
            CSR_MASK_ENABLE: cfg_ff.mask_enable <= csr_bus.data[0];
            CSR_MASK_OFFSET: cfg_ff.mask_offset <= csr_bus.data[REG16_W-1:0];
            CSR_SOURCE_SIZE: cfg_ff.source_size <= csr_bus.data[REG16_W-1:0];
            CSR_MASK_SIZE:   cfg_ff.mask_size   <= csr_bus.data[REG16_W-1:0];
            CSR_FORE_COLOR:  cfg_ff.fore_color  <= csr_bus.data[COLOR_W-1:0];
            CSR_BACK_COLOR:  cfg_ff.back_color  <= csr_bus.data[COLOR_W-1:0];
         endcase
      end
   end

   tcco_front #(
      .MAX_CURSOR (MAX_CURSOR),
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .cfg        (cfg_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   tcco_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   tcco_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item),
      .cfg        (cfg_ff),
      .src_req    (src_req),
      .mask_req   (mask_req),
      .src_rdata  (src_rdata),
      .mask_rdata (mask_rdata),
      .rsp_bus    (rsp_bus),
      .stat       (bk_stat)
   );

   tcco_ram #(
      .WIDTH (MAP_W),
      .DEPTH (MAX_CURSOR)
   ) u_src_ram (
      .clock (clock),
      .we    (src_req.we),
      .waddr (src_req.waddr[ADDR_W-1:0]),
      .wdata (src_req.wdata),
      .re    (src_req.re),
      .raddr (src_req.raddr[ADDR_W-1:0]),
      .rdata (src_rdata)
   );

   tcco_ram #(
      .WIDTH (MAP_W),
      .DEPTH (MAX_CURSOR)
   ) u_mask_ram (
      .clock (clock),
      .we    (mask_req.we),
      .waddr (mask_req.waddr[ADDR_W-1:0]),
      .wdata (mask_req.wdata),
      .re    (mask_req.re),
      .raddr (mask_req.raddr[ADDR_W-1:0]),
      .rdata (mask_rdata)
   );

   `ASSERT_ALWAYS(a_cover_color, clock, reset, (rsp_bus.valid && rsp_bus.covered) |-> (rsp_bus.out_pixel[PIXEL_W-1:COLOR_W] == '0), "covered pixel has nonzero top byte")
   `ASSERT_ALWAYS(a_ram_one_op, clock, reset, !(src_req.we && src_req.re) && !(mask_req.we && mask_req.re) && !(src_req.we && mask_req.we), "more than one bitmap access for one item")
   `ASSERT_NEXT(a_hold_rdata, clock, reset, bk_stat.b1_hold, $stable(src_rdata) && $stable(mask_rdata), "bitmap read data changed while lookup stage stalled")
endmodule

FILE: hdl/tcco_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcco_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/tcco_front.sv
// ---------------------------------------------------------------------------
// Overlay front end
// Accepts items, forms cursor and mask coordinates and classifies them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcco_front #(
   parameter int MAX_CURSOR = tcco_pkg::MAX_CURSOR_DEF,
   parameter int COORD_BITS = tcco_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   tcco_req_if.sink           req_bus,
   input  tcco_pkg::cfg_type  cfg,
   output logic               push_valid,
   input  logic               push_ready,
   output tcco_pkg::work_type push_item
);
   import tcco_pkg::*;

   localparam logic [DIM_W-1:0]   DIM_LIM = DIM_W'(MAX_CURSOR);
   localparam logic [ROW_W:0]     ROW_LIM = (ROW_W+1)'(MAX_CURSOR);

   typedef struct packed {
      kind_type                  kind;
      logic signed [DIFF_W-1:0]  sx;
      logic signed [DIFF_W-1:0]  sy;
      logic signed [DIFF_W-1:0]  mx;
      logic signed [DIFF_W-1:0]  my;
      logic [ROW_W-1:0]          row;
      logic [MAP_W-1:0]          data;
   } front_item_type;

   function automatic logic [DIM_W-1:0] clip_dim(input logic [DIM_W-1:0] v);
      return (v > DIM_LIM) ? DIM_LIM : v;
   endfunction

   function automatic logic in_range(input logic signed [DIFF_W-1:0] c,
                                     input logic [DIM_W-1:0] d);
      logic signed [DIFF_W-1:0] d_ext;
      d_ext = $signed({{(DIFF_W-DIM_W){1'b0}}, d});
      return !c[DIFF_W-1] && (c < d_ext);
   endfunction

   front_item_type fr_ff, fr_in;
   logic           fr_valid_ff, fr_valid_in;
   logic           keep;
   logic signed [DIFF_W-1:0] px, py, cx, cy, ox, oy;
   logic           src_in, mask_in;

   assign req_bus.ready = !fr_valid_ff || push_ready;

   always_comb begin
      px = $signed({{(DIFF_W-COORD_BITS){1'b0}}, req_bus.pix_x});
      py = $signed({{(DIFF_W-COORD_BITS){1'b0}}, req_bus.pix_y});
      cx = $signed({{(DIFF_W-REG16_W){cfg.cursor_x[REG16_W-1]}}, cfg.cursor_x});
      cy = $signed({{(DIFF_W-REG16_W){cfg.cursor_y[REG16_W-1]}}, cfg.cursor_y});
      ox = $signed({{(DIFF_W-DIM_W){cfg.mask_offset[7]}}, cfg.mask_offset[7:0]});
      oy = $signed({{(DIFF_W-DIM_W){cfg.mask_offset[15]}}, cfg.mask_offset[15:8]});

      fr_in.sx   = px - cx;
      fr_in.sy   = py - cy;
      fr_in.mx   = px - cx + ox;
      fr_in.my   = py - cy + oy;
      fr_in.row  = req_bus.row_index;
      fr_in.kind = KIND_PIXEL;
      fr_in.data = req_bus.row_bits;
      keep       = 1'b0;

      unique case (req_bus.op)
         OP_PIXEL: begin
            fr_in.data = {{(MAP_W-PIXEL_W){1'b0}}, req_bus.under_pixel};
            keep       = 1'b1;
         end
         OP_LOAD_SRC: begin
            fr_in.kind = KIND_LOAD_SRC;
            keep       = {1'b0, req_bus.row_index} < ROW_LIM;
         end
         OP_LOAD_MASK: begin
            fr_in.kind = KIND_LOAD_MASK;
            keep       = {1'b0, req_bus.row_index} < ROW_LIM;
         end
         default: begin
            keep = 1'b0;   // unused op, dropped
         end
      endcase

      fr_valid_in = fr_valid_ff;
      if (req_bus.ready) begin
         fr_valid_in = req_bus.valid && keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         fr_ff <= fr_in;
      end
   end

   // box tests against the clipped bitmap sizes
   always_comb begin
      src_in  = in_range(fr_ff.sx, clip_dim(cfg.source_size[7:0]))
             && in_range(fr_ff.sy, clip_dim(cfg.source_size[15:8]));
      mask_in = in_range(fr_ff.mx, clip_dim(cfg.mask_size[7:0]))
             && in_range(fr_ff.my, clip_dim(cfg.mask_size[15:8]));

      push_item.kind     = fr_ff.kind;
      push_item.src_row  = (fr_ff.kind == KIND_PIXEL) ? fr_ff.sy[ROW_W-1:0] : fr_ff.row;
      push_item.src_col  = fr_ff.sx[ROW_W-1:0];
      push_item.mask_row = fr_ff.my[ROW_W-1:0];
      push_item.mask_col = fr_ff.mx[ROW_W-1:0];
      push_item.src_in   = src_in;
      push_item.mask_in  = mask_in;
      push_item.use_mask = cfg.mask_enable;
      push_item.data     = fr_ff.data;
   end

   assign push_valid = fr_valid_ff;
endmodule

FILE: hdl/tcco_queue.sv
// ---------------------------------------------------------------------------
// Work queue
// Short FIFO of classified items between the front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcco_queue #(
   parameter int DEPTH = tcco_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  tcco_pkg::work_type push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output tcco_pkg::work_type pop_item
);
   import tcco_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   work_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CNT_FULL;
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule

FILE: hdl/tcco_back.sv
// ---------------------------------------------------------------------------
// Overlay back end
// Writes bitmap rows, looks up source and mask bits and forms the pixel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcco_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  tcco_pkg::work_type      pop_item,
   input  tcco_pkg::cfg_type       cfg,
   output tcco_pkg::ram_req_type   src_req,
   output tcco_pkg::ram_req_type   mask_req,
   input  logic [tcco_pkg::MAP_W-1:0] src_rdata,
   input  logic [tcco_pkg::MAP_W-1:0] mask_rdata,
   tcco_rsp_if.source              rsp_bus,
   output tcco_pkg::back_stat_type stat
);
   import tcco_pkg::*;

   typedef struct packed {
      logic [ROW_W-1:0]   src_col;
      logic [ROW_W-1:0]   mask_col;
      logic               src_in;
      logic               mask_in;
      logic               use_mask;
      logic [PIXEL_W-1:0] under;
   } lookup_type;

   lookup_type         b1_ff, b1_in;
   logic               b1_valid_ff, b1_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] out_pixel_ff, out_pixel_in;
   logic               covered_ff, covered_in;
   logic               b2_ready, b1_adv, pop, pop_pix;
   logic               fg;

   assign b2_ready  = !rsp_valid_ff || rsp_bus.ready;
   assign b1_adv    = b1_valid_ff && b2_ready;
   assign pop_ready = !b1_valid_ff || b2_ready;
   assign pop       = pop_valid && pop_ready;
   assign pop_pix   = pop && (pop_item.kind == KIND_PIXEL);

   // loads write in queue order, so a later pixel sees the new row
   always_comb begin
      src_req.we     = pop && (pop_item.kind == KIND_LOAD_SRC);
      src_req.waddr  = pop_item.src_row;
      src_req.wdata  = pop_item.data;
      src_req.re     = pop_pix;
      src_req.raddr  = pop_item.src_row;

      mask_req.we    = pop && (pop_item.kind == KIND_LOAD_MASK);
      mask_req.waddr = pop_item.src_row;
      mask_req.wdata = pop_item.data;
      mask_req.re    = pop_pix;
      mask_req.raddr = pop_item.mask_row;

      b1_in.src_col  = pop_item.src_col;
      b1_in.mask_col = pop_item.mask_col;
      b1_in.src_in   = pop_item.src_in;
      b1_in.mask_in  = pop_item.mask_in;
      b1_in.use_mask = pop_item.use_mask;
      b1_in.under    = pop_item.data[PIXEL_W-1:0];

      b1_valid_in = b1_valid_ff;
      if (pop_pix) begin
         b1_valid_in = 1'b1;
      end else if (b1_adv) begin
         b1_valid_in = 1'b0;
      end
   end

   // read data sits in the RAM output registers alongside b1
   always_comb begin
      covered_in = b1_ff.use_mask ? (b1_ff.mask_in && mask_rdata[b1_ff.mask_col])
                                  : b1_ff.src_in;
      fg         = b1_ff.src_in && src_rdata[b1_ff.src_col];
      if (covered_in) begin
         out_pixel_in = {{(PIXEL_W-COLOR_W){1'b0}}, fg ? cfg.fore_color : cfg.back_color};
      end else begin
         out_pixel_in = b1_ff.under;
      end

      rsp_valid_in = rsp_valid_ff;
      if (b1_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_pix) begin
         b1_ff <= b1_in;
      end
      if (b1_adv) begin
         out_pixel_ff <= out_pixel_in;
         covered_ff   <= covered_in;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_pixel = out_pixel_ff;
   assign rsp_bus.covered   = covered_ff;

   assign stat.b1_hold = b1_valid_ff && !b2_ready;
endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Cursor overlay testbench
// Preloads both bitmaps, runs directed pixels at box edges, size limits,
// mask offsets and cursor extremes, then random register settings with
// mixed pixel, row load and unused-op items under bursty traffic and rsp
// backpressure. Every result is checked against an in-bench overlay model.
// ---------------------------------------------------------------------------

module testbench;
   import tcco_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int HALF_PERIOD   = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int STALL_LIMIT   = 2000;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_ITEMS   = 100;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               covered;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tcco_req_if req_bus();
   tcco_rsp_if rsp_bus();
   tcco_csr_if csr_bus();

   two_color_cursor_overlay_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   // shadow registers and bitmaps
   cfg_type          regs;
   logic [MAP_W-1:0] source_map [MAX_CURSOR_DEF];
   logic [MAP_W-1:0] mask_map [MAX_CURSOR_DEF];

   pixel_result_type expected_pixels [$];

   int error_count   = 0;
   int pixels_sent   = 0;
   int covered_count = 0;
   int rows_loaded   = 0;
   int reg_writes    = 0;
   int idle_cycles   = 0;
   int ready_mode    = 0;
   int mode_left     = 0;
   int level_left    = 0;

   always #HALF_PERIOD clock = ~clock;

   // ---------------- overlay model ----------------

   function automatic int box_dim(logic [DIM_W-1:0] v);
      return (v > MAX_CURSOR_DEF) ? MAX_CURSOR_DEF : int'(v);
   endfunction

   function automatic bit in_box(logic [REG16_W-1:0] size, int cx, int cy);
      return cx >= 0 && cx < box_dim(size[7:0]) && cy >= 0 && cy < box_dim(size[15:8]);
   endfunction

   function automatic int origin_col();
      return regs.cursor_x;
   endfunction

   function automatic int origin_row();
      return regs.cursor_y;
   endfunction

   function automatic int mask_dx();
      return $signed(regs.mask_offset[7:0]);
   endfunction

   function automatic int mask_dy();
      return $signed(regs.mask_offset[15:8]);
   endfunction

   function automatic logic [11:0] screen_coord(int v);
      return v[11:0];
   endfunction

   function automatic pixel_result_type overlay_pixel(logic [11:0] x, logic [11:0] y,
                                                      logic [PIXEL_W-1:0] under);
      int               sx, sy, mx, my;
      bit               cov, fore;
      pixel_result_type r;
      sx = int'(x) - origin_col();
      sy = int'(y) - origin_row();
      if (regs.mask_enable) begin
         mx  = sx + mask_dx();
         my  = sy + mask_dy();
         cov = in_box(regs.mask_size, mx, my) && mask_map[my][mx];
      end else begin
         cov = in_box(regs.source_size, sx, sy);
      end
      if (cov) begin
         fore      = in_box(regs.source_size, sx, sy) && source_map[sy][sx];
         r.pixel   = {8'h00, fore ? regs.fore_color : regs.back_color};
         r.covered = 1'b1;
      end else begin
         r.pixel   = under;
         r.covered = 1'b0;
      end
      return r;
   endfunction

   // ---------------- drivers ----------------

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (idx)
         CSR_CURSOR_X:    regs.cursor_x    = value[15:0];
         CSR_CURSOR_Y:    regs.cursor_y    = value[15:0];
         CSR_MASK_ENABLE: regs.mask_enable = value[0];
         CSR_MASK_OFFSET: regs.mask_offset = value[15:0];
         CSR_SOURCE_SIZE: regs.source_size = value[15:0];
         CSR_MASK_SIZE:   regs.mask_size   = value[15:0];
         CSR_FORE_COLOR:  regs.fore_color  = value;
         CSR_BACK_COLOR:  regs.back_color  = value;
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic send_item(logic [OP_W-1:0] op, logic [11:0] x, logic [11:0] y,
                            logic [PIXEL_W-1:0] under, logic [ROW_W-1:0] row,
                            logic [MAP_W-1:0] bits);
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.pix_x       <= x;
      req_bus.pix_y       <= y;
      req_bus.under_pixel <= under;
      req_bus.row_index   <= row;
      req_bus.row_bits    <= bits;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      case (op)
         OP_PIXEL: begin
            expected_pixels.push_back(overlay_pixel(x, y, under));
            pixels_sent++;
         end
         OP_LOAD_SRC: begin
            source_map[row] = bits;
            rows_loaded++;
         end
         OP_LOAD_MASK: begin
            mask_map[row] = bits;
            rows_loaded++;
         end
         default: ;
      endcase
   endtask

   // pixel at a source coordinate relative to the current cursor origin
   task automatic pixel_at(int sx, int sy);
      send_item(OP_PIXEL, screen_coord(origin_col() + sx), screen_coord(origin_row() + sy),
                $urandom, $urandom, {$urandom, $urandom});
   endtask

   task automatic hold_off(int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
   endtask

   // wait until every pixel result is back and any trailing load has landed
   task automatic settle();
      hold_off(1);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      write_reg(CSR_CURSOR_X,    {8'h00, c.cursor_x});
      write_reg(CSR_CURSOR_Y,    {8'h00, c.cursor_y});
      write_reg(CSR_MASK_ENABLE, {23'd0, c.mask_enable});
      write_reg(CSR_MASK_OFFSET, {8'h00, c.mask_offset});
      write_reg(CSR_SOURCE_SIZE, {8'h00, c.source_size});
      write_reg(CSR_MASK_SIZE,   {8'h00, c.mask_size});
      write_reg(CSR_FORE_COLOR,  c.fore_color);
      write_reg(CSR_BACK_COLOR,  c.back_color);
   endtask

   // ---------------- random settings ----------------

   function automatic logic [15:0] random_origin();
      case ($urandom_range(0, 9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return $urandom;
         default: return $urandom_range(0, 4160) - 64;
      endcase
   endfunction

   function automatic logic [7:0] random_dim();
      case ($urandom_range(0, 7))
         0:       return 8'd0;
         1:       return 8'd64;
         2:       return $urandom_range(65, 128);
         default: return $urandom_range(1, 64);
      endcase
   endfunction

   function automatic logic [7:0] random_offset();
      case ($urandom_range(0, 7))
         0:       return 8'h80;
         1:       return 8'h7F;
         default: return $urandom_range(0, 80) - 40;
      endcase
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      c.cursor_x    = random_origin();
      c.cursor_y    = random_origin();
      c.mask_enable = $urandom_range(0, 1);
      c.mask_offset = {random_offset(), random_offset()};
      c.source_size = {random_dim(), random_dim()};
      c.mask_size   = {random_dim(), random_dim()};
      c.fore_color  = random_color();
      c.back_color  = random_color();
      return c;
   endfunction

   task automatic random_item();
      int          pick, sx, sy;
      logic [11:0] x, y;
      pick = $urandom_range(0, 99);
      x    = $urandom;
      y    = $urandom;
      if (pick < 12) begin
         send_item(OP_LOAD_SRC, x, y, $urandom, $urandom, {$urandom, $urandom});
      end else if (pick < 20) begin
         send_item(OP_LOAD_MASK, x, y, $urandom, $urandom, {$urandom, $urandom});
      end else if (pick < 23) begin
         send_item(OP_UNUSED, x, y, $urandom, $urandom, {$urandom, $urandom});
      end else begin
         // mostly aim at the cursor, or at the mask box when the mask is on
         if ($urandom_range(0, 9) < 8) begin
            sx = $urandom_range(0, 72) - 4;
            sy = $urandom_range(0, 72) - 4;
            if (regs.mask_enable && $urandom_range(0, 1)) begin
               sx -= mask_dx();
               sy -= mask_dy();
            end
            x = screen_coord(origin_col() + sx);
            y = screen_coord(origin_row() + sy);
         end
         send_item(OP_PIXEL, x, y, $urandom, $urandom, {$urandom, $urandom});
      end
   endtask

   // ---------------- tests ----------------

   // every row of both maps gets written before any pixel can read it
   task automatic load_bitmaps();
      for (int r = 0; r < MAX_CURSOR_DEF; r++) begin
         send_item(OP_LOAD_SRC, $urandom, $urandom, $urandom, r,
                   (r == 0) ? {MAP_W{1'b1}} :
                   (r == MAX_CURSOR_DEF - 1) ? {MAP_W{1'b0}} : {$urandom, $urandom});
         send_item(OP_LOAD_MASK, $urandom, $urandom, $urandom, r,
                   (r == 0) ? {MAP_W{1'b1}} :
                   (r == MAX_CURSOR_DEF - 1) ? {MAP_W{1'b0}} : {$urandom, $urandom});
      end
   endtask

   // registers still at reset: empty boxes, everything passes through
   task automatic test_reset_registers();
      send_item(OP_PIXEL, 12'd0, 12'd0, 32'hFFFF_FFFF, '0, '0);
      send_item(OP_PIXEL, 12'hFFF, 12'hFFF, 32'h0000_0000, '1, '1);
   endtask

   task automatic test_source_box();
      settle();
      write_reg(CSR_CURSOR_X, 24'd100);
      write_reg(CSR_CURSOR_Y, 24'd50);
      write_reg(CSR_SOURCE_SIZE, 24'h004040);
      write_reg(CSR_FORE_COLOR, 24'hFFFFFF);
      write_reg(CSR_BACK_COLOR, 24'h000000);
      write_reg(CSR_MASK_ENABLE, 24'd0);
      pixel_at(0, 0);
      pixel_at(63, 63);
      pixel_at(63, 0);
      pixel_at(31, 31);
      pixel_at(-1, 0);
      pixel_at(64, 10);
      pixel_at(5, -1);
      pixel_at(5, 64);
   endtask

   task automatic test_box_sizes();
      settle();
      write_reg(CSR_FORE_COLOR, 24'h000000);
      write_reg(CSR_BACK_COLOR, 24'hFFFFFF);
      write_reg(CSR_SOURCE_SIZE, 24'h008080);   // saturates to full size
      pixel_at(63, 63);
      pixel_at(64, 0);
      settle();
      write_reg(CSR_SOURCE_SIZE, 24'h000040);   // zero height
      pixel_at(0, 0);
      settle();
      write_reg(CSR_SOURCE_SIZE, 24'h004001);   // one column wide
      pixel_at(0, 5);
      pixel_at(1, 5);
   endtask

   task automatic test_mask_overlay();
      settle();
      write_reg(CSR_CURSOR_X, 24'd300);
      write_reg(CSR_CURSOR_Y, 24'd300);
      write_reg(CSR_SOURCE_SIZE, 24'h004040);
      write_reg(CSR_MASK_SIZE, 24'h001020);
      write_reg(CSR_MASK_OFFSET, 24'h007F7F);
      write_reg(CSR_MASK_ENABLE, 24'd1);
      write_reg(CSR_FORE_COLOR, 24'h123456);
      write_reg(CSR_BACK_COLOR, 24'hABCDEF);
      pixel_at(-127, -127);
      pixel_at(-96, -127);    // last column inside the mask box
      pixel_at(-100, -112);   // mask row 15
      send_item(OP_UNUSED, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF, '1, '1);
      settle();
      write_reg(CSR_MASK_OFFSET, 24'h008080);
      pixel_at(130, 128);
      settle();
      write_reg(CSR_MASK_OFFSET, 24'h000000);
      // a row load directly followed by a pixel that reads it
      send_item(OP_LOAD_SRC, '0, '0, '0, 6'd2, {$urandom, $urandom});
      send_item(OP_LOAD_MASK, '0, '0, '0, 6'd2, {MAP_W{1'b1}});
      pixel_at(7, 2);
      send_item(OP_LOAD_MASK, '0, '0, '0, 6'd3, {MAP_W{1'b0}});
      pixel_at(7, 3);
      settle();
      write_reg(CSR_MASK_SIZE, 24'h000000);
      pixel_at(0, 0);
   endtask

   task automatic test_cursor_extremes();
      settle();
      write_reg(CSR_MASK_ENABLE, 24'd0);
      write_reg(CSR_CURSOR_X, 24'h008000);
      write_reg(CSR_CURSOR_Y, 24'h007FFF);
      send_item(OP_PIXEL, 12'd0, 12'd0, 32'hA5A5_A5A5, '0, '0);
      send_item(OP_PIXEL, 12'hFFF, 12'hFFF, 32'h5A5A_5A5A, '0, '0);
      settle();
      write_reg(CSR_CURSOR_X, 24'h00FFF6);     // -10
      write_reg(CSR_CURSOR_Y, 24'h00FFFB);     // -5
      send_item(OP_PIXEL, 12'd0, 12'd0, 32'h0, '0, '0);
      settle();
      write_reg(CSR_CURSOR_X, 24'd4090);
      write_reg(CSR_CURSOR_Y, 24'd4090);
      send_item(OP_PIXEL, 12'hFFF, 12'hFFF, 32'h0, '0, '0);
   endtask

   task automatic test_random_traffic();
      int burst_left;
      burst_left = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         apply_settings(random_settings());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (burst_left == 0) begin
               hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
               burst_left = $urandom_range(1, 40);
            end
            burst_left--;
            random_item();
         end
      end
   endtask

   // ---------------- response side ----------------

   // rsp ready: always-on, random, or long low/high stretches
   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(40, 240);
      end
      mode_left--;
      case (ready_mode)
         0: rsp_bus.ready <= 1'b1;
         1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
         default: begin
            if (level_left == 0) begin
               level_left = rsp_bus.ready ? $urandom_range(1, 16) : $urandom_range(1, 10);
               rsp_bus.ready <= !rsp_bus.ready;
            end else begin
               level_left--;
            end
         end
      endcase
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h covered %b",
                     $time, rsp_bus.out_pixel, rsp_bus.covered);
            error_count++;
         end else begin
            want = expected_pixels.pop_front();
            if (want.covered)
               covered_count++;
            if (rsp_bus.out_pixel !== want.pixel) begin
               $display("%0t: out_pixel mismatch, expected %h actual %h",
                        $time, want.pixel, rsp_bus.out_pixel);
               error_count++;
            end
            if (rsp_bus.covered !== want.covered) begin
               $display("%0t: covered mismatch, expected %b actual %b",
                        $time, want.covered, rsp_bus.covered);
               error_count++;
            end
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_PIXEL;
      req_bus.pix_x       = '0;
      req_bus.pix_y       = '0;
      req_bus.under_pixel = '0;
      req_bus.row_index   = '0;
      req_bus.row_bits    = '0;
      csr_bus.valid       = 1'b0;
      csr_bus.index       = CSR_CURSOR_X;
      csr_bus.data        = '0;
      rsp_bus.ready       = 1'b0;
      regs                = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      load_bitmaps();
      test_reset_registers();
      test_source_box();
      test_box_sizes();
      test_mask_overlay();
      test_cursor_extremes();
      test_random_traffic();
      settle();

      $display("%0d pixel results checked, %0d drawn by the cursor", pixels_sent, covered_count);
      $display("%0d bitmap rows loaded, %0d register writes", rows_loaded, reg_writes);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
